FILE: hdl/rvx_pkg.sv
// Shared types, opcodes and codes of the RV32I executor.
package rvx_pkg;

  localparam int RegCount = 32;
  localparam int RegAddrW = 5;

  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;

  localparam logic       ActInstr = 1'b0;
  localparam logic       ActLoad  = 1'b1;

  localparam logic [1:0] KindFetch = 2'd0;
  localparam logic [1:0] KindLoad  = 2'd1;
  localparam logic [1:0] KindStore = 2'd2;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatIllegal = 2'd1;
  localparam logic [1:0] StatBadLoad = 2'd2;

  typedef struct packed {
    logic [1:0]  request_kind;
    logic [31:0] request_address;
    logic [1:0]  access_size;
    logic [31:0] store_data;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic                pending;
    logic [RegAddrW-1:0] dest;
    logic [2:0]          format;
  } load_state_t;

  typedef struct packed {
    logic [1:0]          count;
    result_t             res0;
    result_t             res1;
    logic                we;
    logic [RegAddrW-1:0] waddr;
    logic [31:0]         wdata;
    logic [31:0]         pc_next;
    load_state_t         ld_next;
  } exec_out_t;

endpackage

FILE: hdl/rvx_if.sv
// Stream interfaces for memory words in and requests out.
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] memory_word;
  modport source (output valid, action, memory_word, input ready);
  modport sink (input valid, action, memory_word, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  request_kind;
  logic [31:0] request_address;
  logic [1:0]  access_size;
  logic [31:0] store_data;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, request_kind, request_address, access_size, store_data,
                  status, last, input ready);
  modport sink (input valid, request_kind, request_address, access_size, store_data,
                status, last, output ready);
endinterface

FILE: hdl/rvx_ram.sv
// Generic single-write, single-read RAM with registered read.
module rvx_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hdl/rvx_regfile.sv
// Register file: two read ports, valid bits for reset, write bypass.
module rvx_regfile (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         re,
  input  logic [rvx_pkg::RegAddrW-1:0] raddr1,
  input  logic [rvx_pkg::RegAddrW-1:0] raddr2,
  input  logic                         we,
  input  logic [rvx_pkg::RegAddrW-1:0] waddr,
  input  logic [31:0]                  wdata,
  output logic [31:0]                  rdata1,
  output logic [31:0]                  rdata2
);
  import rvx_pkg::*;

  localparam int Depth = 1 << RegAddrW;

  logic [Depth-1:0] valid;
  logic             we_eff;
  logic [31:0]      ram1, ram2;
  logic             vld1, vld2, fwd1, fwd2;
  logic [31:0]      fwd_data;

  assign we_eff = we && (waddr != '0) &&
                  ({1'b0, waddr} < (RegAddrW + 1)'(RegCount));

  rvx_ram #(.Width(32), .Depth(Depth)) u_ram1 (
    .clk(clk), .we(we_eff), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr1), .rdata(ram1)
  );

  rvx_ram #(.Width(32), .Depth(Depth)) u_ram2 (
    .clk(clk), .we(we_eff), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr2), .rdata(ram2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we_eff) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      vld1     <= valid[raddr1];
      vld2     <= valid[raddr2];
      fwd1     <= we_eff && (waddr == raddr1);
      fwd2     <= we_eff && (waddr == raddr2);
      fwd_data <= wdata;
    end
  end

  assign rdata1 = fwd1 ? fwd_data : (vld1 ? ram1 : '0);
  assign rdata2 = fwd2 ? fwd_data : (vld2 ? ram2 : '0);
endmodule

FILE: hdl/rvx_execute.sv
// Decode and execute of one instruction or load return.
module rvx_execute (
  input  logic                 action,
  input  logic [31:0]          word,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  input  logic [31:0]          pc,
  input  rvx_pkg::load_state_t ld,
  output rvx_pkg::exec_out_t   eo
);
  import rvx_pkg::*;

  logic [6:0]  opcode, f7;
  logic [4:0]  rd, rs2;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, bop, alu_res, ld_val, st_data;
  logic        alt, is_reg, alu_ok, take, br_ok;
  logic [1:0]  fstat;
  logic [31:0] fnext;

  assign opcode = word[6:0];
  assign rd     = word[11:7];
  assign f3     = word[14:12];
  assign rs2    = word[24:20];
  assign f7     = word[31:25];
  assign imm_i  = {{20{word[31]}}, word[31:20]};
  assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign pc4    = pc + 32'd4;
  assign alt    = (f7 == 7'h20);
  assign is_reg = (opcode == OpReg);
  assign bop    = is_reg ? b : ((f3 == 3'd1 || f3 == 3'd5) ? {27'b0, rs2} : imm_i);

  always_comb begin
    alu_ok  = 1'b1;
    alu_res = '0;
    case (f3)
      3'd0: begin
        alu_ok  = !(is_reg && f7 != 7'h0 && !alt);
        alu_res = (is_reg && alt) ? a - bop : a + bop;
      end
      3'd1: begin
        alu_ok  = (f7 == 7'h0);
        alu_res = a << bop[4:0];
      end
      3'd2: begin
        alu_ok  = !(is_reg && f7 != 7'h0);
        alu_res = {31'b0, $signed(a) < $signed(bop)};
      end
      3'd3: begin
        alu_ok  = !(is_reg && f7 != 7'h0);
        alu_res = {31'b0, a < bop};
      end
      3'd4: begin
        alu_ok  = !(is_reg && f7 != 7'h0);
        alu_res = a ^ bop;
      end
      3'd5: begin
        alu_ok  = (f7 == 7'h0) || alt;
        alu_res = alt ? 32'($signed(a) >>> bop[4:0]) : a >> bop[4:0];
      end
      3'd6: begin
        alu_ok  = !(is_reg && f7 != 7'h0);
        alu_res = a | bop;
      end
      default: begin
        alu_ok  = !(is_reg && f7 != 7'h0);
        alu_res = a & bop;
      end
    endcase
  end

  always_comb begin
    br_ok = 1'b1;
    take  = 1'b0;
    case (f3)
      3'd0: take = (a == b);
      3'd1: take = (a != b);
      3'd4: take = $signed(a) < $signed(b);
      3'd5: take = $signed(a) >= $signed(b);
      3'd6: take = a < b;
      3'd7: take = a >= b;
      default: br_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (ld.format[1:0])
      2'd0:    ld_val = ld.format[2] ? {24'b0, word[7:0]} : {{24{word[7]}}, word[7:0]};
      2'd1:    ld_val = ld.format[2] ? {16'b0, word[15:0]} : {{16{word[15]}}, word[15:0]};
      default: ld_val = word;
    endcase
  end

  always_comb begin
    case (f3)
      3'd0:    st_data = {24'b0, b[7:0]};
      3'd1:    st_data = {16'b0, b[15:0]};
      default: st_data = b;
    endcase
  end

  always_comb begin
    eo          = '0;
    eo.pc_next  = pc;
    eo.ld_next  = ld;
    fstat       = StatOk;
    fnext       = pc4;
    eo.count    = 2'd1;
    eo.waddr    = rd;
    if (action == ActLoad) begin
      if (!ld.pending) begin
        eo.count = 2'd0;
      end else begin
        eo.we              = 1'b1;
        eo.waddr           = ld.dest;
        eo.wdata           = ld_val;
        eo.ld_next.pending = 1'b0;
      end
    end else if (ld.pending) begin
      eo.count = 2'd0;
    end else begin
      unique case (opcode)
        OpReg, OpImm: begin
          if (alu_ok) begin
            eo.we    = 1'b1;
            eo.wdata = alu_res;
          end else begin
            fstat = StatIllegal;
          end
        end
        OpLoad: begin
          if (f3 == 3'd3 || f3 == 3'd7) begin
            fstat = StatBadLoad;
          end else if (f3 == 3'd6) begin
            fstat = StatIllegal;
          end else begin
            eo.ld_next.pending = 1'b1;
            eo.ld_next.dest    = rd;
            eo.ld_next.format  = f3;
          end
        end
        OpStore: begin
          if (f3 > 3'd2) begin
            fstat = StatIllegal;
          end else begin
            eo.count = 2'd2;
          end
        end
        OpLui: begin
          eo.we    = 1'b1;
          eo.wdata = {word[31:12], 12'b0};
        end
        OpAuipc: begin
          eo.we    = 1'b1;
          eo.wdata = {word[31:12], 12'b0} + pc;
        end
        OpBranch: begin
          if (!br_ok) begin
            fstat = StatIllegal;
          end else if (take) begin
            fnext = pc + imm_b;
          end
        end
        OpJal: begin
          eo.we    = 1'b1;
          eo.wdata = pc4;
          fnext    = pc + imm_j;
        end
        OpJalr: begin
          if (f3 != 3'd0) begin
            fstat = StatIllegal;
          end else begin
            eo.we    = 1'b1;
            eo.wdata = pc4;
            fnext    = (a + imm_i) & ~32'h1;
          end
        end
        default: fstat = StatIllegal;
      endcase
    end

    if (eo.count != 2'd0 && !eo.ld_next.pending) begin
      eo.pc_next = fnext;
    end

    if (action == ActInstr && !ld.pending && opcode == OpLoad && eo.ld_next.pending) begin
      eo.res0 = '{request_kind: KindLoad, request_address: a + imm_i,
                  access_size: f3[1:0], store_data: '0, status: StatOk, last: 1'b1};
    end else if (eo.count == 2'd2) begin
      eo.res0 = '{request_kind: KindStore, request_address: a + imm_s,
                  access_size: f3[1:0], store_data: st_data, status: StatOk, last: 1'b0};
      eo.res1 = '{request_kind: KindFetch, request_address: fnext,
                  access_size: SizeWord, store_data: '0, status: StatOk, last: 1'b1};
    end else begin
      eo.res0 = '{request_kind: KindFetch, request_address: fnext,
                  access_size: SizeWord, store_data: '0, status: fstat, last: 1'b1};
    end
  end
endmodule

FILE: hdl/rvx_outbuf.sv
// Two-entry result buffer that takes up to two beats at once.
module rvx_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [1:0]       push_count,
  input  rvx_pkg::result_t push0,
  input  rvx_pkg::result_t push1,
  output logic             can_push,
  rvx_out_if.source        result
);
  import rvx_pkg::*;

  result_t    slot0, slot1;
  logic [1:0] count;
  logic       pop;

  assign pop      = result.valid && result.ready;
  assign can_push = (count == 2'd0) || (count == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= push_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= push0;
      slot1 <= push1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign result.valid           = (count != 2'd0);
  assign result.request_kind    = slot0.request_kind;
  assign result.request_address = slot0.request_address;
  assign result.access_size     = slot0.access_size;
  assign result.store_data      = slot0.store_data;
  assign result.status          = slot0.status;
  assign result.last            = slot0.last;
endmodule

FILE: hdl/rv32i_instruction_executor.sv
// Top level of the RV32I executor: input stage, register file, execute, result buffer.
// An accepted beat and its operands are registered; execute then fills the buffer.
// Throughput: one beat per cycle while the buffer can take it; a store places two
// result beats and holds execute until the buffer is empty or its last beat is taken.
// Reset: rst clears pc, load state, register valid bits and buffer; all registers read zero.
module rv32i_instruction_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [31:0] cfg_write_data,
  rvx_in_if.sink      instr,
  rvx_out_if.source   result
);
  import rvx_pkg::*;

  logic        ex_valid, ex_action, fire, accept, can_push;
  logic [31:0] ex_word, pc, a, b;
  load_state_t ld;
  exec_out_t   eo;

  assign fire        = ex_valid && can_push;
  assign instr.ready = !ex_valid || fire;
  assign accept      = instr.valid && instr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (instr.ready) begin
      ex_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_action <= instr.action;
      ex_word   <= instr.memory_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      ld <= '0;
    end else if (cfg_write_enable) begin
      pc <= cfg_write_data;
    end else if (fire) begin
      pc <= eo.pc_next;
      ld <= eo.ld_next;
    end
  end

  rvx_regfile u_regfile (
    .clk(clk), .rst(rst), .re(accept),
    .raddr1(instr.memory_word[19:15]), .raddr2(instr.memory_word[24:20]),
    .we(fire && eo.we), .waddr(eo.waddr), .wdata(eo.wdata),
    .rdata1(a), .rdata2(b)
  );

  rvx_execute u_execute (
    .action(ex_action), .word(ex_word), .a(a), .b(b), .pc(pc), .ld(ld), .eo(eo)
  );

  rvx_outbuf u_outbuf (
    .clk(clk), .rst(rst), .push(fire), .push_count(eo.count),
    .push0(eo.res0), .push1(eo.res1), .can_push(can_push), .result(result)
  );
endmodule
